[src/bpa_pkg.sv]
// bpa_pkg: shared sizes, reset values and codes for the bitmap page allocator
// no dependencies; used by bitmap_page_allocator and bpa_checker

package bpa_pkg;

  // map geometry
  localparam int PAGE_COUNT = 131072;
  localparam int WORD_BITS  = 32;
  localparam int MAP_WORDS  = (PAGE_COUNT + WORD_BITS - 1) / WORD_BITS;

  localparam int PAGE_W = $clog2(PAGE_COUNT);      // page number
  localparam int CNT_W  = $clog2(PAGE_COUNT + 1);  // page count, 0..PAGE_COUNT
  localparam int BIT_W  = $clog2(WORD_BITS);       // bit within a map word
  localparam int ADDR_W = $clog2(MAP_WORDS);       // map word address

  // register reset values
  localparam int RESET_TOTAL    = 131072;
  localparam int RESET_RESERVED = 256;
  localparam int RESET_TOP      = (RESET_TOTAL > PAGE_COUNT) ? PAGE_COUNT : RESET_TOTAL;
  localparam int RESET_FREE     = (RESET_TOP > RESET_RESERVED) ?
                                  (RESET_TOP - RESET_RESERVED) : 0;

  typedef enum logic [1:0] {
    OP_ALLOC = 2'd0,
    OP_FREE  = 2'd1,
    OP_CLEAR = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    STAT_OK          = 2'd0,
    STAT_OUT_OF_MEM  = 2'd1,
    STAT_BAD_PAGE    = 2'd2,
    STAT_DOUBLE_FREE = 2'd3
  } status_e;

  typedef enum logic {
    REG_TOTAL    = 1'b0,
    REG_RESERVED = 1'b1
  } reg_e;

endpackage

[src/bitmap_page_allocator.sv]
// bitmap_page_allocator: free-page bitmap in a word memory, walked by a small sequencer
// depends on bpa_pkg

// One bit per physical page (1 = free), packed 32 pages to a word in a
// 4096-word memory with one write and one registered read port, plus a
// free-page count. A command is taken when start is high and busy is low;
// its single result appears on the result ports for exactly one cycle,
// marked by result_valid_o, and cannot be held off. Per command:
// allocate walks the map one word per cycle from word 0 until it finds a
// free page, passes the total or reaches the last word; free reads the
// page's word and then answers; a page at or above the total is rejected
// straight from idle; clear rewrites every map word, one per cycle; the
// unused opcode answers ok straight from idle. After reset the block
// rebuilds the map for the reset register values in a pass with busy
// high and no result; register writes are taken during that pass.
// Registers should only be written while no command is in flight.

module bitmap_page_allocator (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // command side
  input  logic                           start,
  output logic                           busy,
  input  logic [1:0]                     operation_i,
  input  logic [bpa_pkg::PAGE_W-1:0]     page_number_i,
  // register write port
  input  logic                           cfg_we_i,
  input  logic                           cfg_idx_i,
  input  logic [bpa_pkg::CNT_W-1:0]      cfg_wdata_i,
  // result side
  output logic                           result_valid_o,
  output logic [1:0]                     status_o,
  output logic [bpa_pkg::PAGE_W-1:0]     granted_page_o,
  output logic [bpa_pkg::CNT_W-1:0]      free_count_o
);

  localparam int WB = bpa_pkg::WORD_BITS;
  localparam int BW = bpa_pkg::BIT_W;
  localparam int AW = bpa_pkg::ADDR_W;
  localparam int CW = bpa_pkg::CNT_W;
  localparam int PW = bpa_pkg::PAGE_W;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CLEAR,
    S_SCAN,
    S_FREE_CHK
  } state_e;

  // free mask of one map word at base page for the range [res, top)
  function automatic logic [WB-1:0] rebuild_word(input logic [CW-1:0] base,
                                                  input logic [CW-1:0] res,
                                                  input logic [CW-1:0] top);
    logic [WB-1:0] lo_mask;
    logic [WB-1:0] hi_mask;
    logic [CW-1:0] lo_off;
    logic [CW-1:0] hi_off;
    lo_off = res - base;
    hi_off = top - base;
    if (res <= base) begin
      lo_mask = '1;
    end else if (lo_off >= CW'(WB)) begin
      lo_mask = '0;
    end else begin
      lo_mask = {WB{1'b1}} << lo_off[BW-1:0];
    end
    if (top <= base) begin
      hi_mask = '0;
    end else if (hi_off >= CW'(WB)) begin
      hi_mask = '1;
    end else begin
      hi_mask = ~({WB{1'b1}} << hi_off[BW-1:0]);
    end
    return lo_mask & hi_mask;
  endfunction

  // architectural registers
  logic [CW-1:0] total_q;
  logic [CW-1:0] reserved_q;
  logic [CW-1:0] free_total_q;

  // sequencer
  state_e        state_q;
  logic          from_reset_q;   // current clear pass is the one after reset
  logic [AW-1:0] clr_addr_q;
  logic [CW-1:0] clr_top_q;
  logic [CW-1:0] clr_res_q;
  logic [AW-1:0] scan_q;         // next word to read
  logic [AW-1:0] chk_addr_q;     // word whose data sits in rd_data_q
  logic [PW-1:0] page_q;

  // map memory
  logic [WB-1:0] free_map [bpa_pkg::MAP_WORDS];
  logic [WB-1:0] rd_data_q;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [WB-1:0] mem_wdata;

  // datapath
  logic [CW-1:0] eff_top;
  logic [CW-1:0] chk_base;
  logic          past_top;
  logic          hit;
  logic [BW-1:0] hit_idx;
  logic [PW-1:0] hit_page;
  logic          hit_beyond;
  logic          free_bit;
  logic [WB-1:0] clr_word;
  logic [CW-1:0] clr_free;
  logic          clr_last;

  // total saturated at the map size
  assign eff_top = (total_q > CW'(bpa_pkg::PAGE_COUNT)) ? CW'(bpa_pkg::PAGE_COUNT) : total_q;

  // scan datapath: lowest free bit of the word just read
  assign chk_base = CW'({chk_addr_q, {BW{1'b0}}});
  assign past_top = (chk_base >= eff_top);

  always_comb begin
    hit     = 1'b0;
    hit_idx = '0;
    for (int i = WB - 1; i >= 0; i--) begin
      if (rd_data_q[i]) begin
        hit     = 1'b1;
        hit_idx = BW'(i);
      end
    end
  end

  assign hit_page   = {chk_addr_q, hit_idx};
  assign hit_beyond = (CW'(hit_page) >= eff_top);

  assign free_bit = rd_data_q[page_q[BW-1:0]];

  // rebuild datapath
  assign clr_word = rebuild_word(CW'({clr_addr_q, {BW{1'b0}}}), clr_res_q, clr_top_q);
  assign clr_free = (clr_top_q > clr_res_q) ? (clr_top_q - clr_res_q) : '0;
  assign clr_last = (clr_addr_q == AW'(bpa_pkg::MAP_WORDS - 1));

  assign busy = (state_q != S_IDLE);

  // memory port control
  always_comb begin
    rd_en     = 1'b0;
    rd_addr   = scan_q;
    mem_we    = 1'b0;
    mem_waddr = clr_addr_q;
    mem_wdata = clr_word;
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          rd_en = 1'b1;
          if (operation_i == bpa_pkg::OP_FREE) begin
            rd_addr = page_number_i[PW-1:BW];
          end else begin
            rd_addr = '0;
          end
        end
      end
      S_CLEAR: begin
        mem_we = 1'b1;
      end
      S_SCAN: begin
        rd_en     = 1'b1;
        rd_addr   = scan_q;
        mem_waddr = chk_addr_q;
        mem_wdata = rd_data_q & ~(WB'(1) << hit_idx);
        if (!past_top && hit && !hit_beyond) begin
          mem_we = 1'b1;
        end
      end
      S_FREE_CHK: begin
        mem_waddr = page_q[PW-1:BW];
        mem_wdata = rd_data_q | (WB'(1) << page_q[BW-1:0]);
        if (!free_bit) begin
          mem_we = 1'b1;
        end
      end
      default: begin
        rd_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      free_map[mem_waddr] <= mem_wdata;
    end
    if (rd_en) begin
      rd_data_q <= free_map[rd_addr];
    end
  end

  // sequencer, registers and result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_CLEAR;
      from_reset_q   <= 1'b1;
      clr_addr_q     <= '0;
      clr_top_q      <= CW'(bpa_pkg::RESET_TOP);
      clr_res_q      <= CW'(bpa_pkg::RESET_RESERVED);
      total_q        <= CW'(bpa_pkg::RESET_TOTAL);
      reserved_q     <= CW'(bpa_pkg::RESET_RESERVED);
      free_total_q   <= CW'(bpa_pkg::RESET_FREE);
      scan_q         <= '0;
      chk_addr_q     <= '0;
      page_q         <= '0;
      result_valid_o <= 1'b0;
      status_o       <= bpa_pkg::STAT_OK;
      granted_page_o <= '0;
      free_count_o   <= CW'(bpa_pkg::RESET_FREE);
    end else begin
      result_valid_o <= 1'b0;

      if (cfg_we_i) begin
        unique case (bpa_pkg::reg_e'(cfg_idx_i))
          bpa_pkg::REG_TOTAL:    total_q    <= cfg_wdata_i;
          bpa_pkg::REG_RESERVED: reserved_q <= cfg_wdata_i;
          default:               total_q    <= total_q;
        endcase
      end

      unique case (state_q)
        S_IDLE: begin
          if (start) begin
            page_q <= page_number_i;
            unique case (bpa_pkg::op_e'(operation_i))
              bpa_pkg::OP_ALLOC: begin
                // word 0 is being read now, word 1 goes out next
                chk_addr_q <= '0;
                scan_q     <= AW'(1);
                state_q    <= S_SCAN;
              end
              bpa_pkg::OP_FREE: begin
                if (CW'(page_number_i) >= eff_top) begin
                  result_valid_o <= 1'b1;
                  status_o       <= bpa_pkg::STAT_BAD_PAGE;
                  granted_page_o <= '0;
                  free_count_o   <= free_total_q;
                end else begin
                  state_q <= S_FREE_CHK;
                end
              end
              bpa_pkg::OP_CLEAR: begin
                clr_addr_q <= '0;
                clr_top_q  <= eff_top;
                clr_res_q  <= reserved_q;
                state_q    <= S_CLEAR;
              end
              default: begin
                // unused opcode: answer ok, change nothing
                result_valid_o <= 1'b1;
                status_o       <= bpa_pkg::STAT_OK;
                granted_page_o <= '0;
                free_count_o   <= free_total_q;
              end
            endcase
          end
        end

        S_SCAN: begin
          // one word checked per cycle while the next read is in flight
          scan_q     <= scan_q + AW'(1);
          chk_addr_q <= scan_q;
          priority if (past_top) begin
            result_valid_o <= 1'b1;
            status_o       <= bpa_pkg::STAT_OUT_OF_MEM;
            granted_page_o <= '0;
            free_count_o   <= free_total_q;
            state_q        <= S_IDLE;
          end else if (hit) begin
            result_valid_o <= 1'b1;
            if (hit_beyond) begin
              status_o       <= bpa_pkg::STAT_OUT_OF_MEM;
              granted_page_o <= '0;
              free_count_o   <= free_total_q;
            end else begin
              status_o       <= bpa_pkg::STAT_OK;
              granted_page_o <= hit_page;
              free_count_o   <= free_total_q - CW'(1);
              free_total_q   <= free_total_q - CW'(1);
            end
            state_q <= S_IDLE;
          end else if (chk_addr_q == AW'(bpa_pkg::MAP_WORDS - 1)) begin
            result_valid_o <= 1'b1;
            status_o       <= bpa_pkg::STAT_OUT_OF_MEM;
            granted_page_o <= '0;
            free_count_o   <= free_total_q;
            state_q        <= S_IDLE;
          end else begin
            state_q <= S_SCAN;
          end
        end

        S_FREE_CHK: begin
          result_valid_o <= 1'b1;
          granted_page_o <= '0;
          if (free_bit) begin
            status_o     <= bpa_pkg::STAT_DOUBLE_FREE;
            free_count_o <= free_total_q;
          end else begin
            status_o     <= bpa_pkg::STAT_OK;
            free_count_o <= free_total_q + CW'(1);
            free_total_q <= free_total_q + CW'(1);
          end
          state_q <= S_IDLE;
        end

        S_CLEAR: begin
          // one map word rewritten per cycle
          clr_addr_q <= clr_addr_q + AW'(1);
          if (clr_last) begin
            free_total_q <= clr_free;
            from_reset_q <= 1'b0;
            if (!from_reset_q) begin
              result_valid_o <= 1'b1;
              status_o       <= bpa_pkg::STAT_OK;
              granted_page_o <= '0;
              free_count_o   <= clr_free;
            end
            state_q <= S_IDLE;
          end
        end

        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule

[src/bpa_checker.sv]
// bpa_checker: port-level checks for the bitmap page allocator, bound into bitmap_page_allocator
// depends on bpa_pkg and bitmap_page_allocator

module bpa_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       start,
  input logic                       busy,
  input logic                       result_valid_o,
  input logic [1:0]                 status_o,
  input logic [bpa_pkg::PAGE_W-1:0] granted_page_o,
  input logic [bpa_pkg::CNT_W-1:0]  free_count_o
);

  // a result only shows while the block is free for the next command
  a_result_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> !busy)
    else $error("result shown while busy");

  // an accepted command either answers at once or keeps the block busy
  a_accept_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (busy || result_valid_o))
    else $error("accepted command neither busy nor answered");

  // failed commands grant nothing
  a_fail_no_grant: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && status_o != bpa_pkg::STAT_OK) |-> (granted_page_o == '0))
    else $error("page granted on failed command");

  // failed commands leave the free count as last reported
  a_fail_count_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && status_o != bpa_pkg::STAT_OK) |-> $stable(free_count_o))
    else $error("free count changed on failed command");

  // idle block stays idle without a command
  a_idle_stays: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!busy && !start) |=> !busy)
    else $error("busy without a command");

endmodule

bind bitmap_page_allocator bpa_checker u_bpa_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .busy           (busy),
  .result_valid_o (result_valid_o),
  .status_o       (status_o),
  .granted_page_o (granted_page_o),
  .free_count_o   (free_count_o)
);
